@@ src/wfalu_pkg.sv @@
// shared constants, operation codes and pipeline control type of the wide fixed-point alu
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package wfalu_pkg;

  localparam int LIMB_W  = 64;
  localparam int NLIMB   = 4;
  localparam int WORD_W  = LIMB_W * NLIMB;
  localparam int SHIFT_W = 8;

  // multiplier digits and product columns
  localparam int DIG_W   = 32;
  localparam int NDIG    = WORD_W / DIG_W;
  localparam int KEEP_LO = WORD_W / 2;
  localparam int PROD_W  = KEEP_LO + WORD_W;
  localparam int NCOL    = PROD_W / DIG_W;
  localparam int CARRY_W = $clog2(NDIG);
  localparam int COL_W   = 2 * DIG_W + CARRY_W;
  localparam int VEC_W   = PROD_W + 2 * DIG_W;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_NEG = 3'd2,
    KIND_MUL = 3'd3,
    KIND_SHR = 3'd4,
    KIND_SHL = 3'd5
  } kind_t;

  // load enables of the multiplier's register stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ src/wfalu_if.sv @@
// valid/ready channel interfaces for operation and result transactions
// depends on nothing; limb widths match wfalu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wfalu_op_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] a_limb0;
  logic [63:0] a_limb1;
  logic [63:0] a_limb2;
  logic [63:0] a_limb3;
  logic [63:0] b_limb0;
  logic [63:0] b_limb1;
  logic [63:0] b_limb2;
  logic [63:0] b_limb3;
  logic [7:0]  shift_amount;

  modport source (
    output valid, kind, a_limb0, a_limb1, a_limb2, a_limb3,
           b_limb0, b_limb1, b_limb2, b_limb3, shift_amount,
    input  ready
  );
  modport sink (
    input  valid, kind, a_limb0, a_limb1, a_limb2, a_limb3,
           b_limb0, b_limb1, b_limb2, b_limb3, shift_amount,
    output ready
  );
endinterface

interface wfalu_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] r_limb0;
  logic [63:0] r_limb1;
  logic [63:0] r_limb2;
  logic [63:0] r_limb3;

  modport source (
    output valid, r_limb0, r_limb1, r_limb2, r_limb3,
    input  ready
  );
  modport sink (
    input  valid, r_limb0, r_limb1, r_limb2, r_limb3,
    output ready
  );
endinterface

`default_nettype wire

@@ src/wide_fixed_point_alu_unit.sv @@
// top level of the wide fixed-point alu: handshake, pipeline valid chain, result select
// depends on wfalu_pkg, wfalu_if, wfalu_logic and wfalu_mult
`timescale 1ns / 1ps
`default_nettype none

// 256-bit fixed-point alu (Q128.128 operands as four 64-bit limbs). kind selects
// add, subtract (a - b), negate of a, unsigned multiply returning product bits
// 128..383, logical shift right or shift left of a by shift_amount; add, subtract
// and negate wrap modulo 2^256, and the unused codes 6 and 7 return zero.
// res.valid rises once a transaction has passed all four register stages, and
// a new one is taken every cycle while op.ready is high. the stages are the
// multiplier's: a stage of 32x32 digit products loaded
// at the accepting edge, a stage of column sums, a stage of paired 384-bit adds
// and a last 384-bit add into the output register. the other operations are done
// in the first stage and ride along. op.ready drops only when all four stages hold
// a transaction and res.ready is low; a stalled stage keeps its transaction.

module wide_fixed_point_alu_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  wfalu_op_if.sink     op,
  wfalu_res_if.source  res
);
  import wfalu_pkg::*;

  logic [WORD_W-1:0] a_word, b_word;
  logic [WORD_W-1:0] logic_r, mul_hi;
  pipe_ctl_t         ctl;

  // per-stage valid bits and stage-advance terms
  logic v1, v2, v3, v4;
  logic go1, go2, go3, go4;

  // side path: non-multiply result and multiply flag
  logic              mul1, mul2, mul3;
  logic [WORD_W-1:0] r1, r2, r3;
  logic [WORD_W-1:0] result;

  assign a_word = {op.a_limb3, op.a_limb2, op.a_limb1, op.a_limb0};
  assign b_word = {op.b_limb3, op.b_limb2, op.b_limb1, op.b_limb0};

  // a stage can take new data when empty or when its content moves on
  assign go4 = !v4 || res.ready;
  assign go3 = !v3 || go4;
  assign go2 = !v2 || go3;
  assign go1 = !v1 || go2;

  assign op.ready = go1;

  assign ctl.ld1 = go1 && op.valid;
  assign ctl.ld2 = go2 && v1;
  assign ctl.ld3 = go3 && v2;

  wfalu_logic u_logic (
    .kind         (op.kind),
    .a            (a_word),
    .b            (b_word),
    .shift_amount (op.shift_amount),
    .r            (logic_r)
  );

  wfalu_mult u_mult (
    .clk    (clk),
    .ctl    (ctl),
    .a      (a_word),
    .b      (b_word),
    .mul_hi (mul_hi)
  );

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (go1) v1 <= op.valid;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
      if (go4) v4 <= v3;
    end
  end

  // side path registers, loaded with the same enables as the multiplier
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      r1   <= logic_r;
      mul1 <= (kind_t'(op.kind) == KIND_MUL);
    end
    if (ctl.ld2) begin
      r2   <= r1;
      mul2 <= mul1;
    end
    if (ctl.ld3) begin
      r3   <= r2;
      mul3 <= mul2;
    end
    if (go4 && v3) begin
      result <= mul3 ? mul_hi : r3;
    end
  end

  assign res.valid   = v4;
  assign res.r_limb0 = result[LIMB_W*0 +: LIMB_W];
  assign res.r_limb1 = result[LIMB_W*1 +: LIMB_W];
  assign res.r_limb2 = result[LIMB_W*2 +: LIMB_W];
  assign res.r_limb3 = result[LIMB_W*3 +: LIMB_W];

  // back-pressure reaches the input only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !op.ready |-> (v1 && v2 && v3 && v4 && !res.ready))
    else $error("input stalled while the pipeline has a free stage");

  // an accepted transaction always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (op.valid && op.ready) |=> v1)
    else $error("accepted transaction missing from the first stage");

  // a stage blocked by its successor keeps its transaction and data
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !go4) |=> (v3 && $stable(r3) && $stable(mul3)))
    else $error("stalled stage lost or changed its transaction");

  // a delivered result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && !v3) |=> !res.valid)
    else $error("result repeated after delivery");

  // a held result does not change while it waits
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !res.ready) |=> $stable(result))
    else $error("waiting result changed");

endmodule

`default_nettype wire

@@ src/wfalu_logic.sv @@
// add, subtract, negate and shift datapath of the wide fixed-point alu
// depends on wfalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module wfalu_logic (
  input  wire logic [2:0]                      kind,
  input  wire logic [wfalu_pkg::WORD_W-1:0]    a,
  input  wire logic [wfalu_pkg::WORD_W-1:0]    b,
  input  wire logic [wfalu_pkg::SHIFT_W-1:0]   shift_amount,
  output logic      [wfalu_pkg::WORD_W-1:0]    r
);
  import wfalu_pkg::*;

  always_comb begin
    case (kind_t'(kind))
      KIND_ADD: r = a + b;
      KIND_SUB: r = a - b;
      KIND_NEG: r = WORD_W'(0) - a;
      KIND_SHR: r = a >> shift_amount;
      KIND_SHL: r = a << shift_amount;
      default:  r = '0;  // multiply comes from the array, unused codes give zero
    endcase
  end

endmodule

`default_nettype wire

@@ src/wfalu_mult.sv @@
// three-stage 256x256 multiplier returning product bits 128 to 383
// 32x32 digit products, column sums, pairwise vector sums; depends on wfalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module wfalu_mult (
  input  wire logic                            clk,
  input  wire wfalu_pkg::pipe_ctl_t            ctl,
  input  wire logic [wfalu_pkg::WORD_W-1:0]    a,
  input  wire logic [wfalu_pkg::WORD_W-1:0]    b,
  output logic      [wfalu_pkg::WORD_W-1:0]    mul_hi
);
  import wfalu_pkg::*;

  logic [2*DIG_W-1:0] pp [NDIG][NDIG];
  logic [COL_W-1:0]   col_next [NCOL];
  logic [COL_W-1:0]   col [NCOL];
  logic [VEC_W-1:0]   even_lo, odd_lo, even_hi, odd_hi;
  logic [PROD_W-1:0]  sum_lo, sum_hi, total;

  // stage 1: digit products; those landing at or above bit 384 are never formed
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      for (int i = 0; i < NDIG; i++) begin
        for (int j = 0; j < NDIG; j++) begin
          if (i + j < NCOL) begin
            pp[i][j] <= a[DIG_W*i +: DIG_W] * b[DIG_W*j +: DIG_W];
          end
        end
      end
    end
  end

  // stage 2: sum of each 32-bit column
  always_comb begin
    for (int k = 0; k < NCOL; k++) begin
      col_next[k] = '0;
      for (int i = 0; i < NDIG; i++) begin
        if (k - i >= 0 && k - i < NDIG) begin
          col_next[k] = col_next[k] + COL_W'(pp[i][k-i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      col <= col_next;
    end
  end

  // stage 3: columns split into four non-overlapping vectors, added in pairs
  always_comb begin
    even_lo = '0;
    odd_lo  = '0;
    even_hi = '0;
    odd_hi  = '0;
    for (int m = 0; m < NCOL / 2; m++) begin
      even_lo[2*DIG_W*m +: 2*DIG_W]             = col[2*m][2*DIG_W-1:0];
      odd_lo[2*DIG_W*m + DIG_W +: 2*DIG_W]      = col[2*m+1][2*DIG_W-1:0];
      even_hi[2*DIG_W*(m+1) +: CARRY_W]         = col[2*m][COL_W-1:2*DIG_W];
      odd_hi[2*DIG_W*(m+1) + DIG_W +: CARRY_W]  = col[2*m+1][COL_W-1:2*DIG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      sum_lo <= even_lo[PROD_W-1:0] + odd_lo[PROD_W-1:0];
      sum_hi <= even_hi[PROD_W-1:0] + odd_hi[PROD_W-1:0];
    end
  end

  // final add feeds the output register in the top level
  assign total  = sum_lo + sum_hi;
  assign mul_hi = total[PROD_W-1:KEEP_LO];

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for wide_fixed_point_alu_unit: directed table, then random operations
// depends on wfalu_pkg and wfalu_if from src and on the alu rtl; needs no files at run time

module tb_top;
  import wfalu_pkg::*;

  typedef logic [WORD_W-1:0] word_t;

  // kind codes without a package name; the alu returns zero for both
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int    RESET_CYCLES   = 6;
  localparam int    HOLD_CYCLES    = 40;    // long result-side hold to fill the pipeline
  localparam int    SETTLE_CYCLES  = 12;    // a few pipeline depths after the last result
  localparam int    WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int    MAX_REPORTS    = 100;
  localparam word_t ONES           = '1;
  localparam word_t ONE_Q          = word_t'(1) << KEEP_LO;  // 1.0 in Q128.128

  typedef struct {
    logic [2:0]         kind;
    word_t              a;
    word_t              b;
    logic [SHIFT_W-1:0] sh;
  } alu_op_t;

  typedef struct {
    alu_op_t op;
    bit      typed;   // result below is written by hand
    word_t   result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  wfalu_op_if  op_bus ();
  wfalu_res_if res_bus ();

  wide_fixed_point_alu_unit DUT (
    .clk (clk),
    .rst (rst),
    .op  (op_bus),
    .res (res_bus)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  word_t    pending_results[$];  // oldest expected result first
  dir_row_t stim_table[$];
  int       fail_count    = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_requests = 0;    // bumped by the stimulus side
  int       holds_served  = 0;    // owned by the result-side driver
  int       hold_left     = 0;
  int       stall_cycles  = 0;

  // golden alu: plain wide arithmetic, wraps at 256 bits
  function automatic word_t alu_result(alu_op_t o);
    logic [2*WORD_W-1:0] product;
    word_t               r;
    r = '0;
    case (o.kind)
      KIND_ADD: r = o.a + o.b;
      KIND_SUB: r = o.a - o.b;
      KIND_NEG: r = word_t'(0) - o.a;
      KIND_MUL: begin
        // full unsigned product, keep bits 128..383
        product = {{WORD_W{1'b0}}, o.a} * {{WORD_W{1'b0}}, o.b};
        r = product[KEEP_LO +: WORD_W];
      end
      KIND_SHR: r = o.a >> o.sh;
      KIND_SHL: r = o.a << o.sh;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // limbs biased toward zero, all ones and small values so carries run far
  function automatic word_t random_word();
    word_t w;
    for (int i = 0; i < NLIMB; i++) begin
      case ($urandom_range(7))
        0:       w[i*LIMB_W +: LIMB_W] = '0;
        1:       w[i*LIMB_W +: LIMB_W] = '1;
        2:       w[i*LIMB_W +: LIMB_W] = LIMB_W'($urandom_range(15));
        default: w[i*LIMB_W +: LIMB_W] = {$urandom(), $urandom()};
      endcase
    end
    return w;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t o;
    if ($urandom_range(99) < 96) o.kind = 3'($urandom_range(5));
    else                         o.kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
    o.a = random_word();
    o.b = random_word();
    // shift amounts near limb boundaries a fifth of the time
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(6))
        0:       o.sh = 8'd0;
        1:       o.sh = 8'd63;
        2:       o.sh = 8'd64;
        3:       o.sh = 8'd65;
        4:       o.sh = 8'd127;
        5:       o.sh = 8'd128;
        default: o.sh = 8'd255;
      endcase
    end else begin
      o.sh = 8'($urandom_range(255));
    end
    return o;
  endfunction

  task automatic table_row(input logic [2:0] kind, input word_t a, input word_t b,
                           input logic [SHIFT_W-1:0] sh, input bit typed, input word_t result);
    dir_row_t row;
    row.op.kind = kind;
    row.op.a    = a;
    row.op.b    = b;
    row.op.sh   = sh;
    row.typed   = typed;
    row.result  = result;
    stim_table.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    if (fail_count < MAX_REPORTS)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_op(input alu_op_t o, input bit typed, input word_t typed_result);
    word_t want;
    want = typed ? typed_result : alu_result(o);
    while ($urandom_range(99) < send_idle_pct) begin
      op_bus.valid <= 1'b0;
      @(posedge clk);
    end
    op_bus.valid        <= 1'b1;
    op_bus.kind         <= o.kind;
    op_bus.a_limb0      <= o.a[0*LIMB_W +: LIMB_W];
    op_bus.a_limb1      <= o.a[1*LIMB_W +: LIMB_W];
    op_bus.a_limb2      <= o.a[2*LIMB_W +: LIMB_W];
    op_bus.a_limb3      <= o.a[3*LIMB_W +: LIMB_W];
    op_bus.b_limb0      <= o.b[0*LIMB_W +: LIMB_W];
    op_bus.b_limb1      <= o.b[1*LIMB_W +: LIMB_W];
    op_bus.b_limb2      <= o.b[2*LIMB_W +: LIMB_W];
    op_bus.b_limb3      <= o.b[3*LIMB_W +: LIMB_W];
    op_bus.shift_amount <= o.sh;
    do @(posedge clk); while (op_bus.ready !== 1'b1);
    pending_results.push_back(want);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_op(random_op(), 1'b0, '0);
  endtask

  // drop valid and hold off until every result is back
  task automatic wait_for_drain();
    op_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result-side ready: random idling, or a counted hold when one is requested
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker, limb by limb against the oldest pending result
  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got = {res_bus.r_limb3, res_bus.r_limb2, res_bus.r_limb1, res_bus.r_limb0};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", got, '0);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < NLIMB; i++)
          if (got[i*LIMB_W +: LIMB_W] !== want[i*LIMB_W +: LIMB_W])
            report_mismatch($sformatf("r_limb%0d", i),
                            word_t'(got[i*LIMB_W +: LIMB_W]),
                            word_t'(want[i*LIMB_W +: LIMB_W]));
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (op_bus.valid === 1'b1 && op_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // known values on every alu input from time zero
    rst                 = 1'b1;
    op_bus.valid        = 1'b0;
    op_bus.kind         = '0;
    op_bus.a_limb0      = '0;
    op_bus.a_limb1      = '0;
    op_bus.a_limb2      = '0;
    op_bus.a_limb3      = '0;
    op_bus.b_limb0      = '0;
    op_bus.b_limb1      = '0;
    op_bus.b_limb2      = '0;
    op_bus.b_limb3      = '0;
    op_bus.shift_amount = '0;
    res_bus.ready       = 1'b0;

    // add: zero, wrap at 2^256, carry out of limb 0 with shift_amount ignored
    table_row(KIND_ADD, '0, '0, 8'd0, 1'b1, '0);
    table_row(KIND_ADD, ONES, word_t'(1), 8'd0, 1'b1, '0);
    table_row(KIND_ADD, word_t'({LIMB_W{1'b1}}), word_t'(1), 8'd255, 1'b1,
              word_t'(1) << LIMB_W);
    table_row(KIND_ADD, ONES, ONES, 8'd17, 1'b0, '0);
    // subtract: borrow through every limb, borrow out of limb 1
    table_row(KIND_SUB, '0, word_t'(1), 8'd0, 1'b1, ONES);
    table_row(KIND_SUB, word_t'(1) << LIMB_W, word_t'(1), 8'd0, 1'b1,
              word_t'({LIMB_W{1'b1}}));
    table_row(KIND_SUB, word_t'(1) << (WORD_W-1), ONES, 8'd255, 1'b0, '0);
    // negate: zero stays zero, b ignored, most negative maps to itself
    table_row(KIND_NEG, '0, ONES, 8'd0, 1'b1, '0);
    table_row(KIND_NEG, word_t'(1), '0, 8'd0, 1'b1, ONES);
    table_row(KIND_NEG, word_t'(1) << (WORD_W-1), ONES, 8'd255, 1'b1,
              word_t'(1) << (WORD_W-1));
    // multiply: 1.0 * 1.0, full-scale operands, products that fall off either end
    table_row(KIND_MUL, ONE_Q, ONE_Q, 8'd0, 1'b1, ONE_Q);
    table_row(KIND_MUL, ONES, ONES, 8'd255, 1'b0, '0);
    table_row(KIND_MUL, word_t'(1) << (WORD_W-1), word_t'(1) << (WORD_W-1), 8'd0,
              1'b1, '0);
    table_row(KIND_MUL, word_t'(1), word_t'(1), 8'd0, 1'b1, '0);
    table_row(KIND_MUL, {NLIMB{64'hAAAA_AAAA_AAAA_AAAA}}, {NLIMB{64'h5555_5555_5555_5555}},
              8'd0, 1'b0, '0);
    // right shift: by zero, all the way, whole limbs, one short of a limb
    table_row(KIND_SHR, ONES, '0, 8'd0, 1'b1, ONES);
    table_row(KIND_SHR, ONES, ONES, 8'd255, 1'b1, word_t'(1));
    table_row(KIND_SHR, word_t'(1) << (WORD_W-1), ONES, 8'd64, 1'b0, '0);
    table_row(KIND_SHR, {NLIMB{64'hF0E1_D2C3_B4A5_9687}}, '0, 8'd63, 1'b0, '0);
    // left shift: by zero, all the way, across a limb, two whole limbs
    table_row(KIND_SHL, ONES, '0, 8'd0, 1'b1, ONES);
    table_row(KIND_SHL, ONES, ONES, 8'd255, 1'b1, word_t'(1) << (WORD_W-1));
    table_row(KIND_SHL, word_t'(1), '0, 8'd65, 1'b0, '0);
    table_row(KIND_SHL, {NLIMB{64'h0123_4567_89AB_CDEF}}, ONES, 8'd128, 1'b0, '0);
    // unused kinds return zero whatever the operands
    table_row(KIND_SPARE6, ONES, ONES, 8'd255, 1'b1, '0);
    table_row(KIND_SPARE7, ONES, ONES, 8'd255, 1'b1, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table, back to back
    foreach (stim_table[i]) send_op(stim_table[i].op, stim_table[i].typed, stim_table[i].result);

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 25;
    recv_idle_pct = 72;
    run_random(250);

    // long receiver hold while transactions keep coming, so op.ready has to drop
    send_idle_pct = 0;
    hold_requests++;
    run_random(24);
    wait_for_drain();

    // sender sparse, receiver mostly ready
    send_idle_pct = 72;
    recv_idle_pct = 25;
    run_random(250);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(230);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
